>>> rtl/core/crev_pkg.sv
// Shared types and constants for the color ramp evaluator.
package crev_pkg;

    localparam int POS_W       = 16;
    localparam int CHAN_W      = 12;
    localparam int NUM_CHAN    = 4;
    localparam int COUNT_W     = 3;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 64;
    localparam int MAX_STOPS_DEF = 7;

    localparam logic [CFG_IDX_W-1:0] REG_STOP_COUNT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_STOP_0     = 3'd1;

    localparam logic [1:0] CH_RED   = 2'd0;
    localparam logic [1:0] CH_GREEN = 2'd1;
    localparam logic [1:0] CH_BLUE  = 2'd2;
    localparam logic [1:0] CH_ALPHA = 2'd3;

    typedef struct packed {
        logic [POS_W-1:0]  pos;
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
        logic [CHAN_W-1:0] alpha;
    } t_stop;

    function automatic logic [CHAN_W-1:0] stop_chan(input t_stop s, input logic [1:0] ch);
        logic [CHAN_W-1:0] v;
        case (ch)
            CH_RED:   v = s.red;
            CH_GREEN: v = s.green;
            CH_BLUE:  v = s.blue;
            CH_ALPHA: v = s.alpha;
            default:  v = s.red;
        endcase
        return v;
    endfunction

endpackage

>>> rtl/core/color_ramp_eval_core.sv
// Color ramp evaluator top level with stop registers, search, divider and channel blender.
// When t falls outside an interpolation span, the first or last valid stop is the result;
// when it interpolates, a 16-step restoring divider runs first, then one shared multiplier
// blends the four channels one after another.
// A new transaction may start in the cycle of the result strobe; busy is high until then.
// Synchronous active-low reset restores stop count 1 and all stops to zero.
module color_ramp_eval_core #(
    parameter int MAX_STOPS = crev_pkg::MAX_STOPS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [crev_pkg::POS_W-1:0]      i_ramp_pos,
    input  logic                            i_cfg_we,
    input  logic [crev_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [crev_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    output logic                            o_valid,
    output logic [crev_pkg::CHAN_W-1:0]     o_red,
    output logic [crev_pkg::CHAN_W-1:0]     o_green,
    output logic [crev_pkg::CHAN_W-1:0]     o_blue,
    output logic [crev_pkg::CHAN_W-1:0]     o_alpha
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEL,
        S_DIV,
        S_MUL,
        S_ADD
    } t_state;

    localparam int POS_W  = crev_pkg::POS_W;
    localparam int CHAN_W = crev_pkg::CHAN_W;
    localparam int DIV_CNT_W = $clog2(POS_W);
    localparam int PROD_W = CHAN_W + 1 + POS_W + 1;

    t_state                         r_state;
    crev_pkg::t_stop                r_stop [MAX_STOPS];
    logic [crev_pkg::COUNT_W-1:0]   r_count;
    logic [POS_W-1:0]               r_t;
    crev_pkg::t_stop                r_lo;
    crev_pkg::t_stop                r_hi;
    logic [POS_W-1:0]               r_rem;
    logic [POS_W-1:0]               r_den;
    logic [POS_W-1:0]               r_quo;
    logic [DIV_CNT_W-1:0]           r_div_cnt;
    logic [1:0]                     r_ch;
    logic signed [PROD_W-1:0]       r_prod;
    logic                           r_valid;
    logic [CHAN_W-1:0]              r_red;
    logic [CHAN_W-1:0]              r_green;
    logic [CHAN_W-1:0]              r_blue;
    logic [CHAN_W-1:0]              r_alpha;

    logic [crev_pkg::COUNT_W-1:0]   n_use;
    logic [MAX_STOPS-1:0]           w_sel;
    logic                           w_found;
    logic [63:0]                    w_lo_bits;
    logic [63:0]                    w_hi_bits;
    logic [63:0]                    w_last_bits;
    crev_pkg::t_stop                w_lo;
    crev_pkg::t_stop                w_hi;
    crev_pkg::t_stop                w_last;
    logic [POS_W:0]                 w_rem2;
    logic                           w_ge;
    logic signed [CHAN_W:0]         w_diff;
    logic signed [POS_W:0]          w_frac;
    logic signed [PROD_W-1:0]       w_prod;
    logic signed [PROD_W-1:0]       w_sum;
    logic signed [PROD_W-1:0]       w_shift;
    logic [CHAN_W-1:0]              w_res;
    logic                           w_accept;

    assign w_accept = start && (r_state == S_IDLE);
    assign busy     = (r_state != S_IDLE);

    always_comb begin
        if (r_count == '0) begin
            n_use = crev_pkg::COUNT_W'(1);
        end else if (int'(r_count) > MAX_STOPS) begin
            n_use = crev_pkg::COUNT_W'(MAX_STOPS);
        end else begin
            n_use = r_count;
        end
    end

    always_comb begin
        w_found     = 1'b0;
        w_sel       = '0;
        w_lo_bits   = '0;
        w_hi_bits   = '0;
        w_last_bits = '0;
        for (int i = 1; i < MAX_STOPS; i++) begin
            if (!w_found && (i < int'(n_use)) && (r_stop[i].pos > r_t)) begin
                w_sel[i] = 1'b1;
                w_found  = 1'b1;
            end
        end
        for (int i = 1; i < MAX_STOPS; i++) begin
            w_lo_bits = w_lo_bits | ({64{w_sel[i]}} & r_stop[i-1]);
            w_hi_bits = w_hi_bits | ({64{w_sel[i]}} & r_stop[i]);
        end
        for (int i = 0; i < MAX_STOPS; i++) begin
            w_last_bits = w_last_bits | ({64{i == int'(n_use) - 1}} & r_stop[i]);
        end
    end

    assign w_lo   = crev_pkg::t_stop'(w_lo_bits);
    assign w_hi   = crev_pkg::t_stop'(w_hi_bits);
    assign w_last = crev_pkg::t_stop'(w_last_bits);

    assign w_rem2 = {r_rem, 1'b0};
    assign w_ge   = (w_rem2 >= {1'b0, r_den});

    assign w_diff  = $signed({1'b0, crev_pkg::stop_chan(r_hi, r_ch)})
                   - $signed({1'b0, crev_pkg::stop_chan(r_lo, r_ch)});
    assign w_frac  = $signed({1'b0, r_quo});
    assign w_prod  = w_diff * w_frac;
    assign w_sum   = r_prod + PROD_W'(32768);
    assign w_shift = w_sum >>> POS_W;
    assign w_res   = crev_pkg::stop_chan(r_lo, r_ch) + w_shift[CHAN_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= crev_pkg::COUNT_W'(1);
            for (int j = 0; j < MAX_STOPS; j++) begin
                r_stop[j] <= '0;
            end
        end else if (i_cfg_we) begin
            if (i_cfg_idx == crev_pkg::REG_STOP_COUNT) begin
                r_count <= i_cfg_wdata[crev_pkg::COUNT_W-1:0];
            end
            for (int j = 0; j < MAX_STOPS; j++) begin
                if (int'(i_cfg_idx) == int'(crev_pkg::REG_STOP_0) + j) begin
                    r_stop[j] <= crev_pkg::t_stop'(i_cfg_wdata);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_valid   <= 1'b0;
            r_div_cnt <= '0;
            r_ch      <= crev_pkg::CH_RED;
        end else begin
            r_valid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_t     <= i_ramp_pos;
                        r_state <= S_SEL;
                    end
                end
                S_SEL: begin
                    if (r_stop[0].pos >= r_t) begin
                        r_red   <= r_stop[0].red;
                        r_green <= r_stop[0].green;
                        r_blue  <= r_stop[0].blue;
                        r_alpha <= r_stop[0].alpha;
                        r_valid <= 1'b1;
                        r_state <= S_IDLE;
                    end else if (!w_found) begin
                        r_red   <= w_last.red;
                        r_green <= w_last.green;
                        r_blue  <= w_last.blue;
                        r_alpha <= w_last.alpha;
                        r_valid <= 1'b1;
                        r_state <= S_IDLE;
                    end else begin
                        r_lo      <= w_lo;
                        r_hi      <= w_hi;
                        r_rem     <= r_t - w_lo.pos;
                        r_den     <= w_hi.pos - w_lo.pos;
                        r_quo     <= '0;
                        r_div_cnt <= '0;
                        r_state   <= S_DIV;
                    end
                end
                S_DIV: begin
                    r_rem <= w_ge ? POS_W'(w_rem2 - {1'b0, r_den}) : w_rem2[POS_W-1:0];
                    r_quo <= {r_quo[POS_W-2:0], w_ge};
                    r_div_cnt <= r_div_cnt + 1'b1;
                    if (r_div_cnt == DIV_CNT_W'(POS_W - 1)) begin
                        r_ch    <= crev_pkg::CH_RED;
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_prod  <= w_prod;
                    r_state <= S_ADD;
                end
                S_ADD: begin
                    case (r_ch)
                        crev_pkg::CH_RED:   r_red   <= w_res;
                        crev_pkg::CH_GREEN: r_green <= w_res;
                        crev_pkg::CH_BLUE:  r_blue  <= w_res;
                        crev_pkg::CH_ALPHA: r_alpha <= w_res;
                        default:            r_red   <= w_res;
                    endcase
                    r_ch <= r_ch + 1'b1;
                    if (r_ch == crev_pkg::CH_ALPHA) begin
                        r_valid <= 1'b1;
                        r_state <= S_IDLE;
                    end else begin
                        r_state <= S_MUL;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_valid = r_valid;
    assign o_red   = r_red;
    assign o_green = r_green;
    assign o_blue  = r_blue;
    assign o_alpha = r_alpha;

    // A result strobe always comes with the sequencer back at rest.
    a_valid_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result strobe while busy");

    // An accepted transaction makes the block busy on the next cycle.
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted transaction did not raise busy");

    // The divider never runs with a zero span.
    a_den_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_den != '0))
        else $error("divider started with zero divisor");

    // The partial remainder stays below the divisor.
    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_rem < r_den))
        else $error("divider remainder out of range");

    // A result strobe lasts one cycle.
    a_valid_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe longer than one cycle");

endmodule

>>> test/color_ramp_eval_checker.sv
`timescale 1ns / 100ps
// Checker for the color ramp evaluator: mirrors the stop registers, predicts each color and compares it.
module color_ramp_eval_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    input  logic                            i_busy,
    input  logic [crev_pkg::POS_W-1:0]      i_ramp_pos,
    input  logic                            i_cfg_we,
    input  logic [crev_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [crev_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic                            i_valid,
    input  logic [crev_pkg::CHAN_W-1:0]     i_red,
    input  logic [crev_pkg::CHAN_W-1:0]     i_green,
    input  logic [crev_pkg::CHAN_W-1:0]     i_blue,
    input  logic [crev_pkg::CHAN_W-1:0]     i_alpha,
    output int                              o_fail_count,
    output int                              o_pending,
    output int                              o_checked_count,
    output int                              o_blend_count
);
    import crev_pkg::*;

    typedef struct packed {
        logic [POS_W-1:0]  pos;
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
        logic [CHAN_W-1:0] alpha;
    } t_expected_color;

    logic [COUNT_W-1:0] stop_count;
    t_stop              stops [MAX_STOPS_DEF];
    t_expected_color    expected_colors [$];
    int                 fail_count = 0;
    int                 checked_count = 0;
    int                 blend_count = 0;

    function automatic t_expected_color ramp_color(input logic [POS_W-1:0] t, output bit blended);
        int              n;
        t_stop           sel;
        t_stop           lo_s;
        t_stop           hi_s;
        longint          frac;
        longint          lo [4];
        longint          hi [4];
        longint          v;
        logic [CHAN_W-1:0] mix [4];
        t_expected_color c;
        n = (stop_count == '0) ? 1 : int'(stop_count);
        if (n > MAX_STOPS_DEF) n = MAX_STOPS_DEF;
        blended = 1'b0;
        sel = stops[n-1];
        lo_s = '0;
        hi_s = '0;
        if (stops[0].pos >= t) begin
            sel = stops[0];
        end else begin
            for (int i = 1; i < n; i++) begin
                if (!blended && stops[i].pos > t) begin
                    blended = 1'b1;
                    lo_s = stops[i-1];
                    hi_s = stops[i];
                end
            end
        end
        c = '{t, sel.red, sel.green, sel.blue, sel.alpha};
        if (blended) begin
            frac = (longint'(t - lo_s.pos) << 16) / longint'(hi_s.pos - lo_s.pos);
            lo = '{longint'(lo_s.red), longint'(lo_s.green), longint'(lo_s.blue),
                   longint'(lo_s.alpha)};
            hi = '{longint'(hi_s.red), longint'(hi_s.green), longint'(hi_s.blue),
                   longint'(hi_s.alpha)};
            for (int ch = 0; ch < NUM_CHAN; ch++) begin
                v = (hi[ch] - lo[ch]) * frac + 64'sd32768;
                mix[ch] = CHAN_W'(lo[ch] + (v >>> 16));
            end
            c = '{t, mix[0], mix[1], mix[2], mix[3]};
        end
        return c;
    endfunction

    task automatic check_chan(input string chan_name, input logic [POS_W-1:0] t,
                              input logic [CHAN_W-1:0] want, input logic [CHAN_W-1:0] got);
        if (got !== want) begin
            $display("%0t ns: %s for position 0x%04h expected %0d, got %0d",
                     $time, chan_name, t, want, got);
            fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_expected_color want;
        bit              blended;
        if (!i_rst_n) begin
            stop_count = 3'd1;
            foreach (stops[k]) stops[k] = '0;
            expected_colors.delete();
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == REG_STOP_COUNT) begin
                    stop_count = i_cfg_wdata[COUNT_W-1:0];
                end else begin
                    stops[i_cfg_idx - REG_STOP_0] = i_cfg_wdata;
                end
            end
            if (i_valid) begin
                if (expected_colors.size() == 0) begin
                    $display("%0t ns: color %0d/%0d/%0d/%0d arrived with none expected",
                             $time, i_red, i_green, i_blue, i_alpha);
                    fail_count++;
                end else begin
                    want = expected_colors.pop_front();
                    checked_count++;
                    check_chan("red", want.pos, want.red, i_red);
                    check_chan("green", want.pos, want.green, i_green);
                    check_chan("blue", want.pos, want.blue, i_blue);
                    check_chan("alpha", want.pos, want.alpha, i_alpha);
                end
            end
            if (i_start && !i_busy) begin
                expected_colors.push_back(ramp_color(i_ramp_pos, blended));
                if (blended) blend_count++;
            end
        end
        o_pending       <= expected_colors.size();
        o_fail_count    <= fail_count;
        o_checked_count <= checked_count;
        o_blend_count   <= blend_count;
    end

endmodule

>>> test/color_ramp_eval_core_tb.sv
`timescale 1ns / 100ps
// Testbench top for the color ramp evaluator: stimulus, stop settings and the final verdict.
module color_ramp_eval_core_tb;
    import crev_pkg::*;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  start;
    logic                  busy;
    logic [POS_W-1:0]      i_ramp_pos;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_wdata;
    logic                  o_valid;
    logic [CHAN_W-1:0]     o_red;
    logic [CHAN_W-1:0]     o_green;
    logic [CHAN_W-1:0]     o_blue;
    logic [CHAN_W-1:0]     o_alpha;

    int                    fail_count;
    int                    pending;
    int                    checked_count;
    int                    blend_count;
    int                    item_count = 0;
    int                    setting_count = 0;
    bit                    no_gaps = 1'b0;
    logic [CFG_DATA_W-1:0] count_word;
    t_stop                 ramp_stops [MAX_STOPS_DEF];

    color_ramp_eval_core DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_ramp_pos  (i_ramp_pos),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .o_valid     (o_valid),
        .o_red       (o_red),
        .o_green     (o_green),
        .o_blue      (o_blue),
        .o_alpha     (o_alpha)
    );

    color_ramp_eval_checker u_ramp_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_start         (start),
        .i_busy          (busy),
        .i_ramp_pos      (i_ramp_pos),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_valid         (o_valid),
        .i_red           (o_red),
        .i_green         (o_green),
        .i_blue          (o_blue),
        .i_alpha         (o_alpha),
        .o_fail_count    (fail_count),
        .o_pending       (pending),
        .o_checked_count (checked_count),
        .o_blend_count   (blend_count)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic t_stop make_stop(input logic [POS_W-1:0] pos, input logic [CHAN_W-1:0] r,
                                        input logic [CHAN_W-1:0] g, input logic [CHAN_W-1:0] b,
                                        input logic [CHAN_W-1:0] a);
        return '{pos, r, g, b, a};
    endfunction

    function automatic logic [CHAN_W-1:0] pick_chan();
        int r;
        r = $urandom_range(0, 99);
        if (r < 15) return 12'h000;
        if (r < 30) return 12'hFFF;
        return CHAN_W'($urandom);
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_gaps || r < 40) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Positions cluster on and around the stops so that span edges are hit often.
    function automatic logic [POS_W-1:0] pick_pos();
        int r;
        int p;
        r = $urandom_range(0, 99);
        p = int'(ramp_stops[$urandom_range(0, MAX_STOPS_DEF - 1)].pos);
        if (r < 30) return POS_W'($urandom);
        if (r < 55) return POS_W'(p);
        if (r < 80) return POS_W'($urandom_range(0, 1) ? p + 1 : p - 1);
        if (r < 95) return POS_W'(p + $urandom_range(0, 2047));
        return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
    endfunction

    task automatic send_pos(input logic [POS_W-1:0] t);
        int gap;
        gap = pick_gap();
        start <= 1'b1;
        i_ramp_pos <= t;
        do @(posedge i_clk); while (busy);
        item_count++;
        if (gap > 0) begin
            start <= 1'b0;
            i_ramp_pos <= POS_W'($urandom);
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // The block is idle once every color already requested has come back.
    task automatic load_ramp();
        start <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= REG_STOP_COUNT;
        i_cfg_wdata <= count_word;
        @(posedge i_clk);
        for (int k = 0; k < MAX_STOPS_DEF; k++) begin
            i_cfg_idx <= REG_STOP_0 + CFG_IDX_W'(k);
            i_cfg_wdata <= ramp_stops[k];
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b0;
        setting_count++;
    endtask

    initial begin
        i_rst_n <= 1'b0;
        start <= 1'b0;
        i_ramp_pos <= '0;
        i_cfg_we <= 1'b0;
        i_cfg_idx <= REG_STOP_COUNT;
        i_cfg_wdata <= '0;
        foreach (ramp_stops[k]) ramp_stops[k] = '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_pos(16'h0000);
        send_pos(16'hFFFF);

        count_word = 64'd4;
        ramp_stops[0] = make_stop(16'h1000, 12'hFFF, 12'h000, 12'h800, 12'hFFF);
        ramp_stops[1] = make_stop(16'h4000, 12'h000, 12'hFFF, 12'h7FF, 12'h000);
        ramp_stops[2] = make_stop(16'h8000, 12'hFFF, 12'hFFF, 12'h000, 12'h001);
        ramp_stops[3] = make_stop(16'hF000, 12'h000, 12'h000, 12'hFFF, 12'hFFE);
        ramp_stops[4] = '1;
        ramp_stops[5] = '1;
        ramp_stops[6] = '1;
        load_ramp();
        send_pos(16'h0000);
        send_pos(16'h1000);
        send_pos(16'h1001);
        send_pos(16'h3FFF);
        send_pos(16'h4000);
        send_pos(16'h7FFF);
        send_pos(16'hEFFF);
        send_pos(16'hF000);
        send_pos(16'hFFFF);

        // A zero count behaves as a single stop; the upper data bits must be ignored.
        count_word = 64'hFFFF_FFFF_FFFF_FFF8;
        load_ramp();
        send_pos(16'h0000);
        send_pos(16'h1001);
        send_pos(16'hFFFF);

        count_word = 64'd7;
        ramp_stops[0] = make_stop(16'h0000, 12'h123, 12'hFFF, 12'h000, 12'h800);
        ramp_stops[1] = make_stop(16'h8000, 12'hFFF, 12'h000, 12'hABC, 12'h001);
        ramp_stops[2] = make_stop(16'h2000, 12'h000, 12'h555, 12'hFFF, 12'hFFF);
        ramp_stops[3] = make_stop(16'h8000, 12'h400, 12'h000, 12'h001, 12'h000);
        ramp_stops[4] = '1;
        ramp_stops[5] = make_stop(16'h0001, 12'h321, 12'h654, 12'h987, 12'hCBA);
        ramp_stops[6] = '0;
        load_ramp();
        send_pos(16'h0000);
        send_pos(16'h1FFF);
        send_pos(16'h7FFF);
        send_pos(16'h8000);
        send_pos(16'hFFFE);
        send_pos(16'hFFFF);

        for (int setting = 0; setting < 14; setting++) begin
            int mode;
            int p;
            mode = $urandom_range(0, 9);
            count_word = {$urandom, $urandom};
            count_word[COUNT_W-1:0] = (setting == 0) ? 3'd7 : COUNT_W'($urandom);
            p = $urandom_range(0, 16'h3000);
            for (int k = 0; k < MAX_STOPS_DEF; k++) begin
                if (mode < 2) begin
                    ramp_stops[k] = {$urandom, $urandom};
                end else begin
                    if (k > 0) begin
                        p = p + ((mode < 4) ? $urandom_range(0, 3) : $urandom_range(0, 16'h3000));
                    end
                    if (p > 16'hFFFF) p = 16'hFFFF;
                    ramp_stops[k] = make_stop(POS_W'(p), pick_chan(), pick_chan(), pick_chan(),
                                              pick_chan());
                end
            end
            no_gaps = (setting % 5 == 3);
            load_ramp();
            repeat (75) send_pos(pick_pos());
        end

        start <= 1'b0;
        repeat (2) @(posedge i_clk);
        for (int w = 0; w < 300 && pending != 0; w++) @(posedge i_clk);
        repeat (30) @(posedge i_clk);

        $display("Sent %0d ramp positions over %0d stop settings plus the reset setting.",
                 item_count, setting_count);
        $display("Checked %0d colors, %0d of them interpolated between two stops.",
                 checked_count, blend_count);
        if (pending != 0) begin
            $display("%0t ns: %0d expected colors never arrived", $time, pending);
        end
        if (fail_count == 0 && pending == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
